### rtl/pidl_pkg.sv
// pidl_pkg: shared constants and codes of the positional insert/delete list.
// Used by the channel interfaces, the storage cell and the top level.
// No dependencies.
package pidl_pkg;

	// Default sizes
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int POS_W_DEF      = $clog2(DEPTH_DEF + 1);

	// Field widths fixed by the item format
	localparam int OP_W   = 3;
	localparam int STAT_W = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
	localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
	localparam logic [OP_W-1:0] OP_READOUT   = 3'd6;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

	// Commands broadcast to the cell chain
	typedef logic [1:0] cell_op_t;
	localparam cell_op_t CELL_HOLD = 2'd0;
	localparam cell_op_t CELL_INS  = 2'd1;
	localparam cell_op_t CELL_DEL  = 2'd2;
	localparam cell_op_t CELL_ROT  = 2'd3;

endpackage

### rtl/pidl_ifs.sv
// pidl_req_if / pidl_rsp_if: valid/ready channels of the list block.
// Depends on pidl_pkg for field widths and default sizes.

interface pidl_req_if #(
	parameter int DATA_WIDTH = pidl_pkg::DATA_WIDTH_DEF,
	parameter int POS_W      = pidl_pkg::POS_W_DEF
);
	import pidl_pkg::*;

	logic                         valid;
	logic                         ready;
	logic        [OP_W-1:0]       op;
	logic signed [DATA_WIDTH-1:0] value;
	logic        [POS_W-1:0]      position;

	modport source (output valid, op, value, position, input ready);
	modport sink   (input valid, op, value, position, output ready);
endinterface

interface pidl_rsp_if #(
	parameter int DATA_WIDTH = pidl_pkg::DATA_WIDTH_DEF,
	parameter int POS_W      = pidl_pkg::POS_W_DEF
);
	import pidl_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] element;
	logic                         element_valid;
	logic        [POS_W-1:0]      count;
	logic        [STAT_W-1:0]     status;
	logic                         last;

	modport source (output valid, element, element_valid, count, status, last, input ready);
	modport sink   (input valid, element, element_valid, count, status, last, output ready);
endinterface

### rtl/pidl_cell.sv
// pidl_cell: one list entry of the shifting chain.
// Takes its neighbors' data and a broadcast command; depends on pidl_pkg.
module pidl_cell #(
	parameter int DATA_WIDTH = pidl_pkg::DATA_WIDTH_DEF,
	parameter int IDX_W      = 4,
	parameter int INDEX      = 0
) (
	input  logic                         clk,
	input  pidl_pkg::cell_op_t           cmd,
	input  logic        [IDX_W-1:0]      idx,
	input  logic        [IDX_W-1:0]      last_idx,
	input  logic signed [DATA_WIDTH-1:0] ins_value,
	input  logic signed [DATA_WIDTH-1:0] from_left,
	input  logic signed [DATA_WIDTH-1:0] from_right,
	input  logic signed [DATA_WIDTH-1:0] from_head,
	output logic signed [DATA_WIDTH-1:0] data
);
	import pidl_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic signed [DATA_WIDTH-1:0] data_q;

	// Shift in, shift out or rotate toward the head; hold otherwise
	always_ff @(posedge clk) begin
		unique case (cmd)
			CELL_INS: begin
				if (MY_IDX == idx) begin
					data_q <= ins_value;
				end else if (MY_IDX > idx) begin
					data_q <= from_left;
				end
			end
			CELL_DEL: begin
				if (MY_IDX >= idx) begin
					data_q <= from_right;
				end
			end
			CELL_ROT: begin
				if (MY_IDX == last_idx) begin
					data_q <= from_head;
				end else if (MY_IDX < last_idx) begin
					data_q <= from_right;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

### rtl/positional_insert_delete_list.sv
// positional_insert_delete_list: bounded ordered list kept in a chain of cells.
// Depends on pidl_pkg, pidl_req_if / pidl_rsp_if and pidl_cell.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    op, value, position
//   rsp      out  valid/ready    element, element_valid, count, status, last
//
// A successful insert or delete shifts the chain by one place from the position
// on, and its single result is registered the same cycle.
// A readout of n entries first takes the item, then the first n cells rotate
// toward cell 0, one entry leaves per cycle while rsp can take it, and after
// n steps the list is back in order. No item is taken during a readout.
// A result left untaken on rsp holds req low and holds the chain.
// Reset clears the count and control; the cell contents need no reset.
module positional_insert_delete_list #(
	parameter int DEPTH      = pidl_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = pidl_pkg::DATA_WIDTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	pidl_req_if.sink    req,
	pidl_rsp_if.source  rsp
);
	import pidl_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic                         state_q;
	logic [CW-1:0]                len_q;
	logic [IW-1:0]                rd_idx_q;

	logic                         rsp_valid_q;
	logic signed [DATA_WIDTH-1:0] rsp_element_q;
	logic                         rsp_elem_valid_q;
	logic [CW-1:0]                rsp_count_q;
	logic [STAT_W-1:0]            rsp_status_q;
	logic                         rsp_last_q;

	logic                         out_free;
	logic                         acc;
	logic                         rd_step;
	logic                         rd_last;
	logic [IW-1:0]                last_idx;

	logic [CW-1:0]                dec_len;
	logic [STAT_W-1:0]            dec_st;
	cell_op_t                     dec_op;
	logic [IW-1:0]                dec_idx;
	logic                         dec_read;

	cell_op_t                     chain_op;
	logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign acc       = req.valid && req.ready;
	assign rd_step   = (state_q == S_READ) && out_free;
	assign last_idx  = IW'(len_q - 1'b1);
	assign rd_last   = (rd_idx_q == last_idx);

	// Decode the incoming op against the current count
	always_comb begin
		logic [CW:0] pos_ext;
		logic [CW:0] len_ext;
		pos_ext  = {1'b0, req.position};
		len_ext  = {1'b0, len_q};
		dec_len  = len_q;
		dec_st   = STAT_OK;
		dec_op   = CELL_HOLD;
		dec_idx  = '0;
		dec_read = 1'b0;
		unique case (req.op) inside
			OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
				if (len_q == FULL_CNT) begin
					dec_st = STAT_FULL;
				end else if (req.op == OP_INS_FRONT) begin
					dec_op  = CELL_INS;
					dec_len = len_q + 1'b1;
				end else if (req.op == OP_INS_BACK) begin
					dec_op  = CELL_INS;
					dec_idx = IW'(len_q);
					dec_len = len_q + 1'b1;
				end else if (pos_ext == '0 || pos_ext > len_ext + 1'b1) begin
					dec_st = STAT_BADPOS;
				end else begin
					dec_op  = CELL_INS;
					dec_idx = IW'(req.position - 1'b1);
					dec_len = len_q + 1'b1;
				end
			end
			OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
				if (len_q == '0) begin
					dec_st = STAT_EMPTY;
				end else if (req.op == OP_DEL_FRONT) begin
					dec_op  = CELL_DEL;
					dec_len = len_q - 1'b1;
				end else if (req.op == OP_DEL_BACK) begin
					dec_op  = CELL_DEL;
					dec_idx = last_idx;
					dec_len = len_q - 1'b1;
				end else if (pos_ext == '0 || pos_ext > len_ext) begin
					dec_st = STAT_BADPOS;
				end else begin
					dec_op  = CELL_DEL;
					dec_idx = IW'(req.position - 1'b1);
					dec_len = len_q - 1'b1;
				end
			end
			OP_READOUT: begin
				if (len_q == '0) begin
					dec_st = STAT_EMPTY;
				end else begin
					dec_read = 1'b1;
				end
			end
			default: begin
				dec_st = STAT_OK;
			end
		endcase
	end

	// Command for the chain: update on a transfer, rotate on a readout step
	always_comb begin
		if (acc) begin
			chain_op = dec_op;
		end else if (rd_step) begin
			chain_op = CELL_ROT;
		end else begin
			chain_op = CELL_HOLD;
		end
	end

	// Cell chain
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		pidl_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.IDX_W      (IW),
			.INDEX      (g)
		) u_cell (
			.clk        (clk),
			.cmd        (chain_op),
			.idx        (dec_idx),
			.last_idx   (last_idx),
			.ins_value  (req.value),
			.from_left  (cell_data[(g == 0) ? 0 : g - 1]),
			.from_right (cell_data[(g == DEPTH - 1) ? g : g + 1]),
			.from_head  (cell_data[0]),
			.data       (cell_data[g])
		);
	end

	// Count and readout sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			len_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						len_q    <= dec_len;
						rd_idx_q <= '0;
						if (dec_read) begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					if (rd_step) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						if (rd_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((acc && !dec_read) || rd_step) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register: payload
	always_ff @(posedge clk) begin
		if (acc && !dec_read) begin
			rsp_element_q    <= '0;
			rsp_elem_valid_q <= 1'b0;
			rsp_count_q      <= dec_len;
			rsp_status_q     <= dec_st;
			rsp_last_q       <= 1'b1;
		end else if (rd_step) begin
			rsp_element_q    <= cell_data[0];
			rsp_elem_valid_q <= 1'b1;
			rsp_count_q      <= len_q;
			rsp_status_q     <= STAT_OK;
			rsp_last_q       <= rd_last;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.element       = rsp_element_q;
	assign rsp.element_valid = rsp_elem_valid_q;
	assign rsp.count         = rsp_count_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.last          = rsp_last_q;

	// Checks
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= FULL_CNT)
		else $error("list count exceeds depth");

	a_update_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.op != OP_READOUT) |=> (rsp_valid_q && rsp_last_q))
		else $error("update did not produce a single final result");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> ({1'b0, rd_idx_q} < {1'b0, len_q}))
		else $error("readout index beyond list end");

	a_empty_result_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp_elem_valid_q) |-> rsp_last_q)
		else $error("result without element is not final");

endmodule
